>>> rtl/ladrc_pkg.sv
// shared types, constants, saturating arithmetic and the micro-op program for the adrc speed controller
// no dependencies; used by ladrc_ctrl, ladrc_datapath and the top level
package ladrc_pkg;

    localparam int DW  = 32;
    localparam int FB  = 16;
    localparam int DVW = DW + FB;
    localparam int PCW = 5;
    localparam int CW  = $clog2(DVW);

    localparam logic signed [DW-1:0] VMAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN  = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] TWO   = DW'(2 << FB);
    localparam logic signed [DW-1:0] BOUND = DW'(25 << FB);
    localparam logic signed [DW-1:0] KI    = DW'(((12 << FB) + 5) / 10);

    localparam logic [2:0] REG_PERIOD = 3'd0;
    localparam logic [2:0] REG_WC     = 3'd1;
    localparam logic [2:0] REG_WO     = 3'd2;
    localparam logic [2:0] REG_GAIN   = 3'd3;
    localparam logic [2:0] REG_LIMIT  = 3'd4;

    localparam logic [PCW-1:0] PC_ERR = 5'd15;
    localparam logic [PCW-1:0] PC_FIN = 5'd24;

    typedef enum logic [2:0] {
        OP_LOAD, OP_MUL, OP_POST, OP_ERR, OP_NUM, OP_DIV, OP_FIN
    } op_t;

    typedef enum logic [3:0] {
        M_TWO_WO, M_T1_E, M_GB_PD, M_TP_T2, M_WO_WO, M_TP_T1, M_WC_T2, M_KI_EI
    } msel_t;

    typedef enum logic [2:0] {
        P_T1, P_INNER_SUB, P_INNER_ADD, P_EO, P_ED, P_EI, P_U0
    } psel_t;

    typedef struct packed {
        logic  start;
        logic  exec;
        op_t   op;
        msel_t msel;
        psel_t psel;
    } cmd_t;

    typedef struct packed {
        logic obs_en;
        logic div_done;
        logic out_busy;
    } status_t;

    function automatic logic signed [DW-1:0] sat_mag(input logic neg,
                                                     input logic [DVW-1:0] m);
        logic [DVW-1:0] lim;
        logic signed [DW-1:0] r;
        lim = DVW'(VMAX) + DVW'(neg);
        if (m > lim) begin
            r = neg ? VMIN : VMAX;
        end
        else begin
            r = neg ? -m[DW-1:0] : m[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] add_sat(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? VMIN : VMAX;
        end
        return s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sub_sat(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? VMIN : VMAX;
        end
        return s[DW-1:0];
    endfunction

    function automatic cmd_t prog(input logic [PCW-1:0] pc);
        cmd_t c;
        c = '{start: 1'b0, exec: 1'b0, op: OP_FIN, msel: M_TWO_WO, psel: P_T1};
        case (pc)
            5'd0:  c.op = OP_LOAD;
            5'd1:  begin c.op = OP_MUL;  c.msel = M_TWO_WO; end
            5'd2:  begin c.op = OP_POST; c.psel = P_T1; end
            5'd3:  begin c.op = OP_MUL;  c.msel = M_T1_E; end
            5'd4:  begin c.op = OP_POST; c.psel = P_INNER_SUB; end
            5'd5:  begin c.op = OP_MUL;  c.msel = M_GB_PD; end
            5'd6:  begin c.op = OP_POST; c.psel = P_INNER_ADD; end
            5'd7:  begin c.op = OP_MUL;  c.msel = M_TP_T2; end
            5'd8:  begin c.op = OP_POST; c.psel = P_EO; end
            5'd9:  begin c.op = OP_MUL;  c.msel = M_WO_WO; end
            5'd10: begin c.op = OP_POST; c.psel = P_T1; end
            5'd11: begin c.op = OP_MUL;  c.msel = M_T1_E; end
            5'd12: begin c.op = OP_POST; c.psel = P_T1; end
            5'd13: begin c.op = OP_MUL;  c.msel = M_TP_T1; end
            5'd14: begin c.op = OP_POST; c.psel = P_ED; end
            5'd15: c.op = OP_ERR;
            5'd16: begin c.op = OP_MUL;  c.msel = M_TP_T2; end
            5'd17: begin c.op = OP_POST; c.psel = P_EI; end
            5'd18: begin c.op = OP_MUL;  c.msel = M_WC_T2; end
            5'd19: begin c.op = OP_POST; c.psel = P_T1; end
            5'd20: begin c.op = OP_MUL;  c.msel = M_KI_EI; end
            5'd21: begin c.op = OP_POST; c.psel = P_U0; end
            5'd22: c.op = OP_NUM;
            5'd23: c.op = OP_DIV;
            default: c.op = OP_FIN;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/ladrc_ctrl.sv
// sequencer for the adrc speed controller: steps the micro-op program per sample
// depends on ladrc_pkg
module ladrc_ctrl
    import ladrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_tvalid,
    output logic    in_tready,
    input  status_t sts,
    output cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t         state_reg, state_next;
    logic [PCW-1:0] pc_reg, pc_next;
    cmd_t           step;

    assign in_tready = (state_reg == S_IDLE);

    always_comb
    begin
        step       = prog(pc_reg);
        cmd        = step;
        cmd.start  = in_tvalid && in_tready;
        cmd.exec   = 1'b0;
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_tvalid)
                begin
                    state_next = S_RUN;
                    pc_next    = '0;
                end
            end
            S_RUN:
            begin
                cmd.exec = !(step.op == OP_FIN && sts.out_busy);
                if (cmd.exec)
                begin
                    case (step.op)
                        OP_LOAD: pc_next = sts.obs_en ? pc_reg + 1'b1 : PC_ERR;
                        OP_DIV:  pc_next = sts.div_done ? pc_reg + 1'b1 : pc_reg;
                        OP_FIN:  state_next = S_IDLE;
                        default: pc_next = pc_reg + 1'b1;
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> pc_reg <= PC_FIN)
        else $error("program counter out of range");

    a_fin_back: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && step.op == OP_FIN |=> state_reg == S_IDLE && in_tready)
        else $error("sequencer did not return to idle after a sample");

endmodule

>>> rtl/ladrc_datapath.sv
// datapath of the adrc speed controller: config registers, state, shared multiplier,
// serial divider and output register; depends on ladrc_pkg
module ladrc_datapath
    import ladrc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [63:0]   in_tdata,
    output logic          out_tvalid,
    input  logic          out_tready,
    output logic [95:0]   out_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  cmd_t          cmd,
    output status_t       sts
);

    logic [16:0] tp_reg;
    logic [30:0] wc_reg, wo_reg, lim_reg;
    logic signed [DW-1:0] gb_reg;

    logic signed [DW-1:0] meas_reg, tgt_reg, e_reg, t1_reg, t2_reg;
    logic signed [DW-1:0] eo_reg, ed_reg, ei_reg, pd_reg;
    logic [2*DW-1:0]      p_reg;
    logic                 pneg_reg;
    logic [DVW-1:0]       dvd_reg;
    logic [DW-1:0]        rem_reg, dv_reg;
    logic                 qneg_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 out_valid_reg;
    logic signed [DW-1:0] o_drv_reg, o_eo_reg, o_ed_reg;

    logic signed [DW-1:0] ma, mb, mq, tp_s, wc_s, wo_s, lim_s, ei_sum, num, qs, drv_raw, drv;
    logic [DW-1:0]        ua, ub;
    logic [DW:0]          r33;
    logic                 ge;

    assign cfg_ready = 1'b1;
    assign tp_s  = DW'(tp_reg);
    assign wc_s  = DW'(wc_reg);
    assign wo_s  = DW'(wo_reg);
    assign lim_s = DW'(lim_reg);

    assign sts.obs_en   = (tp_reg != '0) && (wo_reg != '0);
    assign sts.div_done = (cnt_reg == '0);
    assign sts.out_busy = out_valid_reg && !out_tready;

    always_comb
    begin
        case (cmd.msel)
            M_TWO_WO: begin ma = TWO;    mb = wo_s;   end
            M_T1_E:   begin ma = t1_reg; mb = e_reg;  end
            M_GB_PD:  begin ma = gb_reg; mb = pd_reg; end
            M_TP_T2:  begin ma = tp_s;   mb = t2_reg; end
            M_WO_WO:  begin ma = wo_s;   mb = wo_s;   end
            M_TP_T1:  begin ma = tp_s;   mb = t1_reg; end
            M_WC_T2:  begin ma = wc_s;   mb = t2_reg; end
            M_KI_EI:  begin ma = KI;     mb = ei_reg; end
            default:  begin ma = '0;     mb = '0;     end
        endcase
        ua = ma[DW-1] ? DW'(-ma) : DW'(ma);
        ub = mb[DW-1] ? DW'(-mb) : DW'(mb);
        mq = sat_mag(pneg_reg, p_reg[2*DW-1:FB]);

        ei_sum = add_sat(ei_reg, mq);
        if (ei_sum > BOUND)
        begin
            ei_sum = BOUND;
        end
        else if (ei_sum < -BOUND)
        begin
            ei_sum = -BOUND;
        end

        num = sub_sat(t1_reg, ed_reg);

        r33 = {rem_reg, dvd_reg[DVW-1]};
        ge  = (r33 >= {1'b0, dv_reg});

        qs      = sat_mag(qneg_reg, dvd_reg);
        drv_raw = (gb_reg == '0) ? '0 : qs;
        if (drv_raw > lim_s)
        begin
            drv = lim_s;
        end
        else if (drv_raw < -lim_s)
        begin
            drv = -lim_s;
        end
        else
        begin
            drv = drv_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_reg  <= 17'd655;
            wc_reg  <= '0;
            wo_reg  <= '0;
            gb_reg  <= '0;
            lim_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PERIOD: tp_reg  <= cfg_data[16:0];
                REG_WC:     wc_reg  <= cfg_data[30:0];
                REG_WO:     wo_reg  <= cfg_data[30:0];
                REG_GAIN:   gb_reg  <= cfg_data;
                REG_LIMIT:  lim_reg <= cfg_data[30:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eo_reg        <= '0;
            ed_reg        <= '0;
            ei_reg        <= '0;
            pd_reg        <= '0;
            e_reg         <= '0;
            t1_reg        <= '0;
            t2_reg        <= '0;
            p_reg         <= '0;
            pneg_reg      <= 1'b0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            dv_reg        <= '0;
            qneg_reg      <= 1'b0;
            o_drv_reg     <= '0;
            o_eo_reg      <= '0;
            o_ed_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_tready && !(cmd.exec && cmd.op == OP_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.exec)
            begin
                case (cmd.op)
                    OP_LOAD: e_reg  <= sub_sat(eo_reg, meas_reg);
                    OP_ERR:  t2_reg <= sub_sat(tgt_reg, eo_reg);
                    OP_MUL:
                    begin
                        p_reg    <= ua * ub;
                        pneg_reg <= ma[DW-1] ^ mb[DW-1];
                    end
                    OP_POST:
                    begin
                        case (cmd.psel)
                            P_T1:        t1_reg <= mq;
                            P_INNER_SUB: t2_reg <= sub_sat(ed_reg, mq);
                            P_INNER_ADD: t2_reg <= add_sat(t2_reg, mq);
                            P_EO:        eo_reg <= add_sat(eo_reg, mq);
                            P_ED:        ed_reg <= sub_sat(ed_reg, mq);
                            P_EI:        ei_reg <= ei_sum;
                            P_U0:        t1_reg <= add_sat(t1_reg, mq);
                            default:     ;
                        endcase
                    end
                    OP_NUM:
                    begin
                        dvd_reg  <= {(num[DW-1] ? DW'(-num) : DW'(num)), {FB{1'b0}}};
                        dv_reg   <= gb_reg[DW-1] ? DW'(-gb_reg) : DW'(gb_reg);
                        qneg_reg <= num[DW-1] ^ gb_reg[DW-1];
                        rem_reg  <= '0;
                        cnt_reg  <= CW'(DVW - 1);
                    end
                    OP_DIV:
                    begin
                        rem_reg <= ge ? DW'(r33 - {1'b0, dv_reg}) : r33[DW-1:0];
                        dvd_reg <= {dvd_reg[DVW-2:0], ge};
                        if (cnt_reg != '0)
                        begin
                            cnt_reg <= cnt_reg - 1'b1;
                        end
                    end
                    OP_FIN:
                    begin
                        pd_reg        <= drv;
                        o_drv_reg     <= drv;
                        o_eo_reg      <= eo_reg;
                        o_ed_reg      <= ed_reg;
                        out_valid_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            meas_reg <= in_tdata[31:0];
            tgt_reg  <= in_tdata[63:32];
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = {o_ed_reg, o_eo_reg, o_drv_reg};

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.exec && cmd.op == OP_FIN))
        else $error("result appeared without a finish step");

    a_integral_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ei_reg <= BOUND && ei_reg >= -BOUND)
        else $error("integral outside its clamp");

    a_drive_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> o_drv_reg <= lim_s && o_drv_reg >= -lim_s && pd_reg == o_drv_reg)
        else $error("drive outside limit or not stored");

endmodule

>>> rtl/linear_adrc_speed_controller_core.sv
// top level of the linear adrc speed controller: sequencer plus datapath
// depends on ladrc_pkg, ladrc_ctrl and ladrc_datapath
//
// One control sample per input word; samples are processed one at a time. With the observer
// disabled (zero period or zero observer bandwidth) its update steps are skipped. Each
// multiply goes through one shared 32x32 multiplier as a multiply step followed by a post
// step, and the final division by the plant gain runs a restoring divider at one quotient
// bit per cycle. The next sample is taken in the cycle after the previous one has been
// moved into the output register, even if that result has not yet been read; a finish step
// waits while an earlier result is still unread. Configuration writes are always accepted
// and should be done while no sample is in flight.
module linear_adrc_speed_controller_core
    import ladrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_tvalid,
    output logic        in_tready,
    input  logic [63:0] in_tdata,   // measured_speed, target_speed
    output logic        out_tvalid,
    input  logic        out_tready,
    output logic [95:0] out_tdata,  // drive, output_estimate, disturbance_estimate
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cmd_t    cmd;
    status_t sts;

    ladrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (in_tvalid),
        .in_tready (in_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ladrc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tdata   (in_tdata),
        .out_tvalid (out_tvalid),
        .out_tready (out_tready),
        .out_tdata  (out_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

>>> tb/sv/linear_adrc_speed_controller_core_tb.sv
// self-checking testbench for linear_adrc_speed_controller_core: directed table then random
// samples, each result checked against an in-bench q16.16 adrc predictor
// depends on ladrc_pkg and the rtl of the core
module linear_adrc_speed_controller_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ladrc_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 900;

    typedef logic signed [31:0] q_t;
    typedef struct packed {
        q_t disturb;
        q_t est;
        q_t drv;
    } ctl_result_t;
    typedef struct {
        q_t  meas;
        q_t  tgt;
        bit  known;
        q_t  drv;
    } sample_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_tvalid = 1'b0;
    logic        in_tready;
    logic [63:0] in_tdata = '0;
    logic        out_tvalid;
    logic        out_tready = 1'b0;
    logic [95:0] out_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // predictor state and configuration
    logic [16:0] period_r;
    logic [30:0] wc_r, wo_r, limit_r;
    q_t          gain_r;
    q_t          est_out, est_dist, err_int, prev_drv;

    ctl_result_t expected_q[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 26;
    int          recv_idle_pct = 48;
    bit          hold_off = 0;

    always #4 clk = ~clk;

    linear_adrc_speed_controller_core DUT (.*);

    function automatic q_t sat64(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return q_t'(v);
    endfunction

    function automatic q_t qmul(q_t a, q_t b);
        logic [63:0] p;
        logic [63:0] s;
        bit          neg;
        neg = a[31] ^ b[31];
        p = 64'(a < 0 ? -longint'(a) : longint'(a)) * 64'(b < 0 ? -longint'(b) : longint'(b));
        s = p >> 16;
        if (neg) return s > 64'h80000000 ? 32'sh80000000 : q_t'(-longint'(s));
        return s > 64'h7fffffff ? 32'sh7fffffff : q_t'(s);
    endfunction

    function automatic q_t qdiv(q_t n, q_t d);
        logic [127:0] num, quo;
        bit           neg;
        neg = n[31] ^ d[31];
        num = 128'(n < 0 ? -longint'(n) : longint'(n)) << 16;
        quo = num / 128'(d < 0 ? -longint'(d) : longint'(d));
        if (neg) return quo > 128'h80000000 ? 32'sh80000000 : q_t'(-longint'(quo));
        return quo > 128'h7fffffff ? 32'sh7fffffff : q_t'(quo);
    endfunction

    function automatic q_t qadd(q_t a, q_t b);
        return sat64(longint'(a) + longint'(b));
    endfunction

    function automatic q_t qsub(q_t a, q_t b);
        return sat64(longint'(a) - longint'(b));
    endfunction

    function automatic ctl_result_t predict_control(q_t meas, q_t tgt);
        q_t tp, e, inner, nout, ndist, err, u0, drv, lim;
        ctl_result_t r;
        tp = q_t'(period_r);
        lim = q_t'(limit_r);
        if (tp != 0 && wo_r != 0) begin
            e = qsub(est_out, meas);
            inner = qsub(est_dist, qmul(qmul(TWO, q_t'(wo_r)), e));
            inner = qadd(inner, qmul(gain_r, prev_drv));
            nout = qadd(est_out, qmul(tp, inner));
            ndist = qsub(est_dist, qmul(tp, qmul(qmul(q_t'(wo_r), q_t'(wo_r)), e)));
            est_out = nout;
            est_dist = ndist;
        end
        err = qsub(tgt, est_out);
        err_int = qadd(err_int, qmul(err, tp));
        if (err_int > BOUND) err_int = BOUND;
        if (err_int < -BOUND) err_int = -BOUND;
        u0 = qadd(qmul(q_t'(wc_r), err), qmul(KI, err_int));
        drv = 0;
        if (gain_r != 0) drv = qdiv(qsub(u0, est_dist), gain_r);
        if (drv > lim) drv = lim;
        if (drv < -lim) drv = -lim;
        prev_drv = drv;
        r.drv = drv;
        r.est = est_out;
        r.disturb = est_dist;
        return r;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_PERIOD: period_r = val[16:0];
            REG_WC:     wc_r = val[30:0];
            REG_WO:     wo_r = val[30:0];
            REG_GAIN:   gain_r = val;
            REG_LIMIT:  limit_r = val[30:0];
            default: ;
        endcase
    endtask

    task automatic send_sample(q_t meas, q_t tgt, bit known, q_t drv);
        ctl_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            in_tvalid <= 1'b0;
            @(posedge clk);
        end
        in_tvalid <= 1'b1;
        in_tdata <= {tgt, meas};
        do @(posedge clk); while (!in_tready);
        r = predict_control(meas, tgt);
        if (known && r.drv !== drv) begin
            $display("%0t table drive: expected %h actual predictor %h", $realtime, drv, r.drv);
            errors++;
        end
        expected_q.push_back(r);
    endtask

    task automatic drain;
        in_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic q_t rand_q(int mode);
        case (mode)
            0: return q_t'($urandom);
            1: return q_t'($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
            default: return q_t'($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
        endcase
    endfunction

    // receiver side and checker
    always @(posedge clk) begin
        ctl_result_t exp_r, got;
        if (out_tvalid && out_tready) begin
            got = out_tdata;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected word: actual %h", $realtime, out_tdata);
                errors++;
            end
            else begin
                exp_r = expected_q.pop_front();
                if (got.drv !== exp_r.drv) begin
                    $display("%0t drive: expected %h actual %h", $realtime, exp_r.drv, got.drv);
                    errors++;
                end
                if (got.est !== exp_r.est) begin
                    $display("%0t output_estimate: expected %h actual %h",
                             $realtime, exp_r.est, got.est);
                    errors++;
                end
                if (got.disturb !== exp_r.disturb) begin
                    $display("%0t disturbance_estimate: expected %h actual %h",
                             $realtime, exp_r.disturb, got.disturb);
                    errors++;
                end
            end
        end
        out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on handshake activity
    always @(posedge clk) begin
        if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        sample_row_t rows[$];
        logic [31:0] cfg_sets[5][5];
        int s;
        period_r = 17'd655;
        wc_r = '0;
        wo_r = '0;
        gain_r = '0;
        limit_r = '0;
        est_out = '0;
        est_dist = '0;
        err_int = '0;
        prev_drv = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: zero gain, zero drive
        rows = '{
            '{32'sh0001_0000, 32'sh0002_0000, 1, 32'sh0},
            '{32'sh7fffffff, 32'sh80000000, 1, 32'sh0},
            '{32'sh80000000, 32'sh7fffffff, 1, 32'sh0}
        };
        foreach (rows[i]) send_sample(rows[i].meas, rows[i].tgt, rows[i].known, rows[i].drv);
        drain();

        // settings: period, wc, wo, gain, limit
        cfg_sets = '{
            '{32'd655, 32'h0005_0000, 32'h0014_0000, 32'h0002_0000, 32'h0064_0000},
            '{32'd0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff},
            '{32'h10000, 32'h0000_8000, 32'h0, 32'hffff_0000, 32'h0001_0000},
            '{32'h1ffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0},
            '{32'd65, 32'h0000_3000, 32'h0000_8000, 32'h0000_0001, 32'h7fffffff}
        };
        for (s = 0; s < 5; s++) begin
            for (int r = 0; r < 5; r++) write_reg(3'(r), cfg_sets[s][r]);
            write_reg(3'd7, $urandom);
            cfg_valid <= 1'b0;
            case (s)
                2: begin send_idle_pct = 48; recv_idle_pct = 26; end
                4: begin send_idle_pct = 0; recv_idle_pct = 0; end
                default: ;
            endcase
            if (s == 0) begin
                rows = '{
                    '{32'sh0, 32'sh0, 0, 0},
                    '{32'sh7fffffff, 32'sh7fffffff, 0, 0},
                    '{32'sh80000000, 32'sh80000000, 0, 0},
                    '{32'sh0001_0000, 32'shffff_0000, 0, 0},
                    '{32'sh80000000, 32'sh7fffffff, 0, 0}
                };
                foreach (rows[i]) send_sample(rows[i].meas, rows[i].tgt, 0, 0);
                // long receiver stall while samples keep coming
                fork
                    begin
                        hold_off = 1;
                        repeat (600) @(posedge clk);
                        hold_off = 0;
                    end
                    repeat (6) send_sample(rand_q(1), rand_q(1), 0, 0);
                join
            end
            repeat (N_RANDOM / 5) send_sample(rand_q($urandom_range(2)),
                                              rand_q($urandom_range(2)), 0, 0);
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> sim.f
rtl/ladrc_pkg.sv
rtl/ladrc_ctrl.sv
rtl/ladrc_datapath.sv
rtl/linear_adrc_speed_controller_core.sv
tb/sv/linear_adrc_speed_controller_core_tb.sv
